[hw/rtl/sorted_list_table_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the sorted list table
// Shared property forms; the enclosing scope supplies i_clk and i_rst_n.
// ---------------------------------------------------------------------------
`ifndef SORTED_LIST_TABLE_ASSERT_SVH
`define SORTED_LIST_TABLE_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define SLT_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sorted list table check failed");

// Next-cycle implication, disabled during reset
`define SLT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sorted list table check failed");

`endif

[hw/rtl/slt_pkg.sv]
// ---------------------------------------------------------------------------
// Sorted list table package
// Sizes, command and status codes, and sequencer states.
// ---------------------------------------------------------------------------
package slt_pkg;

    localparam int DEPTH   = 64;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int VALUE_W = 32;
    localparam int POS_W   = 6;
    localparam int OCC_W   = 7;

    typedef enum logic [2:0] {
        KIND_INSERT = 3'd0,
        KIND_DELETE = 3'd1,
        KIND_SEARCH = 3'd2,
        KIND_COUNT  = 3'd3,
        KIND_CLEAR  = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_CMP,
        S_FND_RD,
        S_FND_CMP,
        S_DEL_RD,
        S_DEL_WR,
        S_RESP
    } t_state;

endpackage

[hw/rtl/slt_chan_if.sv]
// ---------------------------------------------------------------------------
// Sorted list table channels
// Command and response channels with valid/ready handshake.
// ---------------------------------------------------------------------------
interface slt_cmd_if;
    import slt_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [2:0]                 kind;
    logic signed [VALUE_W-1:0]  value;

    modport source (output valid, output kind, output value, input ready);
    modport sink   (input valid, input kind, input value, output ready);
endinterface

interface slt_rsp_if;
    import slt_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [1:0]                 status;
    logic [POS_W-1:0]           position;
    logic [OCC_W-1:0]           occupancy;
    logic signed [VALUE_W-1:0]  found_value;

    modport source (output valid, output status, output position, output occupancy,
                    output found_value, input ready);
    modport sink   (input valid, input status, input position, input occupancy,
                    input found_value, output ready);
endinterface

[hw/rtl/slt_ram.sv]
// ---------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port, read data registered.
// ---------------------------------------------------------------------------
module slt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/sorted_list_table.sv]
// ---------------------------------------------------------------------------
// Sorted list table
// Ascending table of signed values with insert, delete, search, count, clear.
// ---------------------------------------------------------------------------
// Values live in one RAM with a single read and a single write port, walked
// by a small sequencer with one shared signed comparator. One command is
// taken at a time; the command port is ready only while the block is idle
// and the response has been taken. Count and clear, and refused or empty
// commands, go straight to the response. Insert walks down from the top
// and search walks up from the bottom; delete runs the search to the hit and
// then closes the gap. Each step takes a read state and a compare or write
// state because the RAM read data is registered.
// ---------------------------------------------------------------------------
module sorted_list_table (
    input  logic        i_clk,
    input  logic        i_rst_n,
    slt_cmd_if.sink     i_cmd,
    slt_rsp_if.source   o_rsp
);
    import slt_pkg::*;

    t_state                     r_state, n_state;
    logic [CNT_W-1:0]           r_count, n_count;
    logic [CNT_W-1:0]           r_idx,   n_idx;
    logic [2:0]                 r_kind,  n_kind;
    logic signed [VALUE_W-1:0]  r_value, n_value;
    t_status                    r_status, n_status;
    logic [POS_W-1:0]           r_pos,   n_pos;
    logic signed [VALUE_W-1:0]  r_found, n_found;

    logic                       ram_we;
    logic [IDX_W-1:0]           ram_waddr;
    logic [VALUE_W-1:0]         ram_wdata;
    logic [IDX_W-1:0]           ram_raddr;
    logic [VALUE_W-1:0]         ram_rdata;

    logic                       cmp_gt;
    logic                       cmp_eq;

    // value store
    slt_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // shared comparator: stored entry against the command operand
    assign cmp_gt = $signed(ram_rdata) > r_value;
    assign cmp_eq = ram_rdata == r_value;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    // working and response registers
    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_kind   <= n_kind;
        r_value  <= n_value;
        r_status <= n_status;
        r_pos    <= n_pos;
        r_found  <= n_found;
    end

    // sequencer: next state, RAM control and result
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_idx     = r_idx;
        n_kind    = r_kind;
        n_value   = r_value;
        n_status  = r_status;
        n_pos     = r_pos;
        n_found   = r_found;
        ram_we    = 1'b0;
        ram_waddr = r_idx[IDX_W-1:0];
        ram_wdata = r_value;
        ram_raddr = r_idx[IDX_W-1:0];

        case (r_state)
            S_IDLE: begin
                if (i_cmd.valid) begin
                    n_kind   = i_cmd.kind;
                    n_value  = i_cmd.value;
                    n_status = ST_OK;
                    n_pos    = '0;
                    n_found  = '0;
                    n_state  = S_RESP;
                    case (i_cmd.kind)
                        KIND_INSERT: begin
                            if (r_count == CNT_W'(DEPTH)) begin
                                n_status = ST_FULL;
                            end else begin
                                n_idx   = r_count;
                                n_state = S_INS_RD;
                            end
                        end
                        KIND_DELETE, KIND_SEARCH: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_idx   = '0;
                                n_state = S_FND_RD;
                            end
                        end
                        KIND_COUNT: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                            end
                        end
                        KIND_CLEAR: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                            end
                            n_count = '0;
                        end
                        default: begin
                            n_status = ST_OK;
                        end
                    endcase
                end
            end

            // insert: walk down from the top, moving larger entries up one slot
            S_INS_RD: begin
                if (r_idx == '0) begin
                    ram_we    = 1'b1;
                    ram_waddr = '0;
                    ram_wdata = r_value;
                    n_pos     = '0;
                    n_count   = r_count + CNT_W'(1);
                    n_state   = S_RESP;
                end else begin
                    ram_raddr = IDX_W'(r_idx - CNT_W'(1));
                    n_state   = S_INS_CMP;
                end
            end

            S_INS_CMP: begin
                ram_we = 1'b1;
                if (cmp_gt) begin
                    ram_wdata = ram_rdata;
                    n_idx     = r_idx - CNT_W'(1);
                    n_state   = S_INS_RD;
                end else begin
                    ram_wdata = r_value;
                    n_pos     = POS_W'(r_idx);
                    n_count   = r_count + CNT_W'(1);
                    n_state   = S_RESP;
                end
            end

            // search: walk up from the bottom for the first equal entry
            S_FND_RD: begin
                if (r_idx >= r_count) begin
                    n_status = ST_NOT_FOUND;
                    n_state  = S_RESP;
                end else begin
                    n_state = S_FND_CMP;
                end
            end

            S_FND_CMP: begin
                if (cmp_eq) begin
                    n_pos = POS_W'(r_idx);
                    if (r_kind == KIND_SEARCH) begin
                        n_found = r_value;
                        n_state = S_RESP;
                    end else begin
                        n_state = S_DEL_RD;
                    end
                end else begin
                    n_idx   = r_idx + CNT_W'(1);
                    n_state = S_FND_RD;
                end
            end

            // delete: move every entry above the hit down one slot
            S_DEL_RD: begin
                if ((r_idx + CNT_W'(1)) >= r_count) begin
                    n_count = r_count - CNT_W'(1);
                    n_state = S_RESP;
                end else begin
                    ram_raddr = IDX_W'(r_idx + CNT_W'(1));
                    n_state   = S_DEL_WR;
                end
            end

            S_DEL_WR: begin
                ram_we    = 1'b1;
                ram_wdata = ram_rdata;
                n_idx     = r_idx + CNT_W'(1);
                n_state   = S_DEL_RD;
            end

            // hold the response until the beat is taken
            S_RESP: begin
                if (o_rsp.ready) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // channel outputs
    assign i_cmd.ready       = (r_state == S_IDLE);
    assign o_rsp.valid       = (r_state == S_RESP);
    assign o_rsp.status      = r_status;
    assign o_rsp.position    = r_pos;
    assign o_rsp.occupancy   = OCC_W'(r_count);
    assign o_rsp.found_value = r_found;

endmodule

[hw/rtl/slt_checker.sv]
// ---------------------------------------------------------------------------
// Sorted list table checker
// Port-level properties of the table, bound to the top level.
// ---------------------------------------------------------------------------
`include "sorted_list_table_assert.svh"

module slt_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cmd_valid,
    input  logic                          i_cmd_ready,
    input  logic                          i_rsp_valid,
    input  logic [1:0]                    i_rsp_status,
    input  logic [slt_pkg::OCC_W-1:0]     i_rsp_occupancy,
    input  logic [slt_pkg::VALUE_W-1:0]   i_rsp_found_value
);
    import slt_pkg::*;

    // never take a command while a response beat is pending
    `SLT_ASSERT_SAME(a_busy_while_resp, i_rsp_valid, !i_cmd_ready)

    // a taken command keeps the block busy on the next cycle
    `SLT_ASSERT_NEXT(a_busy_after_accept, i_cmd_valid && i_cmd_ready, !i_cmd_ready)

    // a refused insert only happens at a full table
    `SLT_ASSERT_SAME(a_full_occupancy, i_rsp_valid && (i_rsp_status == ST_FULL),
                     i_rsp_occupancy == OCC_W'(DEPTH))

    // a found value only accompanies a successful command
    `SLT_ASSERT_SAME(a_found_only_ok, i_rsp_valid && (i_rsp_found_value != '0),
                     i_rsp_status == ST_OK)

    // an empty status never reports stored values
    `SLT_ASSERT_SAME(a_empty_zero, i_rsp_valid && (i_rsp_status == ST_EMPTY),
                     i_rsp_occupancy == '0)

endmodule

bind sorted_list_table slt_checker u_slt_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_cmd_valid       (i_cmd.valid),
    .i_cmd_ready       (i_cmd.ready),
    .i_rsp_valid       (o_rsp.valid),
    .i_rsp_status      (o_rsp.status),
    .i_rsp_occupancy   (o_rsp.occupancy),
    .i_rsp_found_value (o_rsp.found_value)
);
